@@ hw/rtl/dcbf_pkg.sv @@
// Shared types and constants for the delta-cycle byte FIFO.
// Used by dcbf_ctrl, dcbf_datapath and delta_cycle_byte_fifo; no dependencies.
`default_nettype none

package dcbf_pkg;

  // Ring size and derived widths
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

  // Item field widths
  localparam int KIND_W  = 2;
  localparam int DATA_W  = 8;
  localparam int LEVEL_W = 5;
  localparam int PAD_W   = 3;
  localparam int OUT_W   = 1 + DATA_W + 2 * LEVEL_W + 2 + PAD_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_UPDATE = 2'd2
  } kind_t;

  // Result item as it sits on m_tdata (last member in the lowest bits)
  typedef struct packed {
    logic [PAD_W-1:0]   pad;
    logic               write_event;
    logic               read_event;
    logic [LEVEL_W-1:0] space;
    logic [LEVEL_W-1:0] available;
    logic [DATA_W-1:0]  read_data;
    logic               accepted;
  } result_t;

  // Controller to datapath command
  typedef struct packed {
    logic load;   // take the input item and register its result
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/delta_cycle_byte_fifo.sv @@
// Top level of the delta-cycle byte FIFO: controller plus datapath.
// Depends on dcbf_pkg, dcbf_ctrl and dcbf_datapath.
//
// Usage
//   Input items arrive on the s_ group: s_tuser carries the kind (write byte,
//   read byte, end of update phase), s_tdata the byte to store on a write.
//   Every input item produces exactly one result item on the m_ group.
//   Reads see only entries made visible at the last update less the reads
//   since; writes see only the space free at the last update less the writes
//   since. An access that would have to wait comes back with accepted low.
//   Result: presented in the cycle after the item is taken.
//   Throughput: one item per cycle; the result register is refilled in the
//   same cycle it is emptied, so s_tready stays high while m_tready is high.
//   When the receiver stalls the held result stays put and s_tready drops
//   until it is taken; no item is lost or repeated.
//   Reset (rst, synchronous) empties the ring, sets the free count to the
//   full depth and clears the visible count and phase counters; s_tready is
//   low while rst is high. Stored bytes are not cleared; they cannot be read
//   before being written.
`default_nettype none

module delta_cycle_byte_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [dcbf_pkg::DATA_W-1:0] s_tdata,  // [7:0] data_in
  input  wire logic [dcbf_pkg::KIND_W-1:0] s_tuser,  // [1:0] kind
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // [0] accepted, [8:1] read_data, [13:9] available, [18:14] space,
  // [19] read_event, [20] write_event, [23:21] zero
  output logic [dcbf_pkg::OUT_W-1:0]      m_tdata
);

  dcbf_pkg::ctl_t    ctl;
  dcbf_pkg::result_t res;

  dcbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  dcbf_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .kind    (s_tuser),
    .data_in (s_tdata),
    .res     (res)
  );

  assign m_tdata = res;

  // An update item always reports accepted
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == dcbf_pkg::KIND_UPDATE) |=> res.accepted)
    else $error("update item not reported as accepted");

  // Event flags only ever come with an accepted result
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res.read_event || res.write_event)) |-> res.accepted)
    else $error("event flag on a result that was not accepted");

  // Readable plus writable never exceeds the ring size
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, res.available} + {1'b0, res.space}
                  <= (dcbf_pkg::LEVEL_W + 1)'(dcbf_pkg::DEPTH)))
    else $error("available plus space exceeds depth");

  // While a result is held, no new item is taken
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !ctl.load)
    else $error("item taken while result register is held");

endmodule

`default_nettype wire

@@ hw/rtl/dcbf_ctrl.sv @@
// Handshake controller for the delta-cycle byte FIFO.
// Depends on dcbf_pkg for the command struct.
`default_nettype none

module dcbf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output dcbf_pkg::ctl_t       ctl
);

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // A new item may enter whenever the result register is empty or draining;
  // nothing is taken while reset is held
  assign s_tready = !rst && ((state == ST_EMPTY) || m_tready);
  assign m_tvalid = (state == ST_FULL);
  assign ctl.load = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    priority if (ctl.load) begin
      state_next = ST_FULL;
    end else if (m_tready) begin
      state_next = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dcbf_datapath.sv @@
// Ring buffer, phase counters and result register of the delta-cycle byte FIFO.
// Depends on dcbf_pkg for widths, kind codes and the result struct.
`default_nettype none

module dcbf_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dcbf_pkg::ctl_t              ctl,
  input  wire logic [dcbf_pkg::KIND_W-1:0] kind,
  input  wire logic [dcbf_pkg::DATA_W-1:0] data_in,
  output dcbf_pkg::result_t                res
);

  logic [dcbf_pkg::DATA_W-1:0] storage [dcbf_pkg::DEPTH];

  logic [dcbf_pkg::IDX_W-1:0] head_index, head_index_next;
  logic [dcbf_pkg::IDX_W-1:0] tail_index, tail_index_next;
  logic [dcbf_pkg::CNT_W-1:0] free_count, free_count_next;
  logic [dcbf_pkg::CNT_W-1:0] visible_count, visible_count_next;
  logic [dcbf_pkg::CNT_W-1:0] phase_reads, phase_reads_next;
  logic [dcbf_pkg::CNT_W-1:0] phase_writes, phase_writes_next;

  logic [dcbf_pkg::CNT_W-1:0] readable, writable;
  logic [dcbf_pkg::CNT_W-1:0] readable_after, writable_after;
  logic [dcbf_pkg::CNT_W:0]   used, used_after;
  logic                       do_write;
  dcbf_pkg::result_t          res_next;
  dcbf_pkg::result_t          res_load;

  // Levels seen by the current item
  assign used     = {1'b0, visible_count} + {1'b0, phase_writes};
  assign readable = (visible_count >= phase_reads) ? visible_count - phase_reads : '0;
  assign writable = ({1'b0, dcbf_pkg::DEPTH_CNT} >= used)
                  ? dcbf_pkg::DEPTH_CNT - used[dcbf_pkg::CNT_W-1:0] : '0;

  always_comb begin
    do_write           = 1'b0;
    head_index_next    = head_index;
    tail_index_next    = tail_index;
    free_count_next    = free_count;
    visible_count_next = visible_count;
    phase_reads_next   = phase_reads;
    phase_writes_next  = phase_writes;
    res_next           = '0;
    unique case (kind)
      dcbf_pkg::KIND_WRITE: begin
        if (writable != '0) begin
          do_write          = 1'b1;
          phase_writes_next = phase_writes + 1'b1;
          tail_index_next   = (tail_index == dcbf_pkg::LAST_IDX) ? '0 : tail_index + 1'b1;
          if (free_count != '0) begin
            free_count_next = free_count - 1'b1;
          end
          res_next.accepted = 1'b1;
        end
      end
      dcbf_pkg::KIND_READ: begin
        if (readable != '0) begin
          phase_reads_next   = phase_reads + 1'b1;
          head_index_next    = (head_index == dcbf_pkg::LAST_IDX) ? '0 : head_index + 1'b1;
          if (free_count < dcbf_pkg::DEPTH_CNT) begin
            free_count_next = free_count + 1'b1;
          end
          res_next.accepted  = 1'b1;
          res_next.read_data = storage[head_index];
        end
      end
      dcbf_pkg::KIND_UPDATE: begin
        res_next.read_event  = (phase_reads != '0);
        res_next.write_event = (phase_writes != '0);
        visible_count_next   = dcbf_pkg::DEPTH_CNT - free_count;
        phase_reads_next     = '0;
        phase_writes_next    = '0;
        res_next.accepted    = 1'b1;
      end
      default: ;  // unused kind: no effect
    endcase
  end

  // Levels reported after the item
  assign used_after     = {1'b0, visible_count_next} + {1'b0, phase_writes_next};
  assign readable_after = (visible_count_next >= phase_reads_next)
                        ? visible_count_next - phase_reads_next : '0;
  assign writable_after = ({1'b0, dcbf_pkg::DEPTH_CNT} >= used_after)
                        ? dcbf_pkg::DEPTH_CNT - used_after[dcbf_pkg::CNT_W-1:0] : '0;

  always_comb begin
    res_load           = res_next;
    res_load.available = dcbf_pkg::LEVEL_W'(readable_after);
    res_load.space     = dcbf_pkg::LEVEL_W'(writable_after);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index    <= '0;
      tail_index    <= '0;
      free_count    <= dcbf_pkg::DEPTH_CNT;
      visible_count <= '0;
      phase_reads   <= '0;
      phase_writes  <= '0;
    end else if (ctl.load) begin
      head_index    <= head_index_next;
      tail_index    <= tail_index_next;
      free_count    <= free_count_next;
      visible_count <= visible_count_next;
      phase_reads   <= phase_reads_next;
      phase_writes  <= phase_writes_next;
    end
  end

  // Byte store and result register: payload only, no reset
  always_ff @(posedge clk) begin
    if (ctl.load && do_write) begin
      storage[tail_index] <= data_in;
    end
    if (ctl.load) begin
      res <= res_load;
    end
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for delta_cycle_byte_fifo: directed and random write/read/update
// items, an item-level predictor of the delayed-visibility ring, and random stalls on both sides.
// Depends on dcbf_pkg and the delta_cycle_byte_fifo RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The kind encoding leaves one value unused; the block must ignore it
  localparam logic [dcbf_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int ITEM_TARGET    = 1200;
  localparam int MAX_GAP        = 10;
  localparam int HOLD_AT        = 500;   // results taken before the long receiver hold-off
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 8;     // wait after the last result before ending the run
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [dcbf_pkg::KIND_W-1:0] kind;
    logic [dcbf_pkg::DATA_W-1:0] data;
  } stim_t;

  logic                          clk;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [dcbf_pkg::DATA_W-1:0]   s_tdata  = '0;
  logic [dcbf_pkg::KIND_W-1:0]   s_tuser  = dcbf_pkg::KIND_UPDATE;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [dcbf_pkg::OUT_W-1:0]    m_tdata;

  delta_cycle_byte_fifo u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the ring and its phase counters.
  // Reads see what was visible at the last update less the reads since;
  // writes see what was free at the last update less the writes since.
  // ---------------------------------------------------------------------------
  logic [dcbf_pkg::DATA_W-1:0] ring_bytes [dcbf_pkg::DEPTH];
  logic [dcbf_pkg::IDX_W-1:0]  ring_head  = '0;
  logic [dcbf_pkg::IDX_W-1:0]  ring_tail  = '0;
  logic [dcbf_pkg::CNT_W-1:0]  free_slots = dcbf_pkg::DEPTH_CNT;
  logic [dcbf_pkg::CNT_W-1:0]  shown      = '0;   // entries made visible at the last update
  logic [dcbf_pkg::CNT_W-1:0]  reads_in_phase  = '0;
  logic [dcbf_pkg::CNT_W-1:0]  writes_in_phase = '0;

  dcbf_pkg::result_t expected_results[$];

  function automatic int readable_bytes();
    return (shown >= reads_in_phase) ? int'(shown) - int'(reads_in_phase) : 0;
  endfunction

  function automatic int writable_slots();
    int used;
    used = int'(shown) + int'(writes_in_phase);
    return (dcbf_pkg::DEPTH >= used) ? dcbf_pkg::DEPTH - used : 0;
  endfunction

  function automatic dcbf_pkg::result_t predict_result(
      input logic [dcbf_pkg::KIND_W-1:0] kind,
      input logic [dcbf_pkg::DATA_W-1:0] data);
    dcbf_pkg::result_t r;
    r = '0;
    case (kind)
      dcbf_pkg::KIND_WRITE: begin
        if (writable_slots() != 0) begin
          writes_in_phase++;
          ring_bytes[ring_tail] = data;
          ring_tail = (ring_tail == dcbf_pkg::LAST_IDX) ? '0 : ring_tail + 1'b1;
          if (free_slots != 0) free_slots--;
          r.accepted = 1'b1;
        end
      end
      dcbf_pkg::KIND_READ: begin
        if (readable_bytes() != 0) begin
          reads_in_phase++;
          r.read_data = ring_bytes[ring_head];
          ring_head = (ring_head == dcbf_pkg::LAST_IDX) ? '0 : ring_head + 1'b1;
          if (free_slots != dcbf_pkg::DEPTH_CNT) free_slots++;
          r.accepted = 1'b1;
        end
      end
      dcbf_pkg::KIND_UPDATE: begin
        // end of phase: everything stored becomes visible, counts restart
        r.read_event  = (reads_in_phase != 0);
        r.write_event = (writes_in_phase != 0);
        shown = dcbf_pkg::DEPTH_CNT - free_slots;
        reads_in_phase  = '0;
        writes_in_phase = '0;
        r.accepted = 1'b1;
      end
      default: ;  // unused kind: no state change, levels still reported
    endcase
    r.available = dcbf_pkg::LEVEL_W'(readable_bytes());
    r.space     = dcbf_pkg::LEVEL_W'(writable_slots());
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store
  // ---------------------------------------------------------------------------
  stim_t pending_items[$];
  int    total_items  = 0;
  int    counted_items = 0;  // items the block acts on (unused kind left out)

  task automatic queue_item(input logic [dcbf_pkg::KIND_W-1:0] kind,
                            input logic [dcbf_pkg::DATA_W-1:0] data);
    pending_items.push_back('{kind: kind, data: data});
    total_items++;
    if (kind != KIND_UNUSED) counted_items++;
  endtask

  // One phase: writes and reads in random order with random bytes, closed by an update.
  // Asking for more than the depth on either side runs into the blocking cases.
  task automatic queue_phase(input int n_writes, input int n_reads);
    while (n_writes > 0 || n_reads > 0) begin
      if (n_reads == 0 || (n_writes > 0 && $urandom_range(0, 1) == 0)) begin
        queue_item(dcbf_pkg::KIND_WRITE, dcbf_pkg::DATA_W'($urandom_range(0, 255)));
        n_writes--;
      end else begin
        queue_item(dcbf_pkg::KIND_READ, dcbf_pkg::DATA_W'($urandom_range(0, 255)));
        n_reads--;
      end
    end
    queue_item(dcbf_pkg::KIND_UPDATE, dcbf_pkg::DATA_W'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, random gap after each, with bursts of no gaps
  // ---------------------------------------------------------------------------
  stim_t next_item;
  int    send_gap    = 0;
  bit    send_burst  = 1'b0;
  int    items_taken = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_result(s_tuser, s_tdata));
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          s_tuser  <= next_item.kind;
          s_tdata  <= next_item.data;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver hold-off: once, after HOLD_AT results, the receiver holds off (hold_left
  // loaded from HOLD_CYCLES) so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results with random stalls and checks them in order.
  // ---------------------------------------------------------------------------
  dcbf_pkg::result_t want;
  dcbf_pkg::result_t got;
  int      recv_wait    = 0;
  bit      recv_burst   = 1'b0;
  int      results_seen = 0;
  int      error_count  = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = dcbf_pkg::result_t'(m_tdata);
        results_seen++;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected result %0d: %h", results_seen, m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.accepted !== want.accepted || got.read_data !== want.read_data ||
              got.available !== want.available || got.space !== want.space ||
              got.read_event !== want.read_event || got.write_event !== want.write_event)
          begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("mismatch on result %0d:", results_seen);
              $display("  expected acc=%0d data=%h avail=%0d space=%0d rev=%0d wev=%0d",
                       want.accepted, want.read_data, want.available, want.space,
                       want.read_event, want.write_event);
              $display("  got      acc=%0d data=%h avail=%0d space=%0d rev=%0d wev=%0d",
                       got.accepted, got.read_data, got.available, got.space,
                       got.read_event, got.write_event);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either side for too long
  int stall_cycles;

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // directed: empty ring, extreme bytes, delayed visibility, unused kind
    queue_item(dcbf_pkg::KIND_READ,   8'h00);  // nothing visible yet: rejected
    queue_item(dcbf_pkg::KIND_UPDATE, 8'hFF);  // update with no traffic: no events
    queue_item(dcbf_pkg::KIND_WRITE,  8'h00);
    queue_item(dcbf_pkg::KIND_WRITE,  8'hFF);
    queue_item(dcbf_pkg::KIND_READ,   8'h33);  // written but not yet visible: rejected
    queue_item(KIND_UNUSED,           8'hAA);  // ignored
    queue_item(dcbf_pkg::KIND_UPDATE, 8'h00);  // write event only
    queue_item(dcbf_pkg::KIND_READ,   8'h00);
    queue_item(dcbf_pkg::KIND_WRITE,  8'h5A);  // space still counted from the last update
    queue_item(dcbf_pkg::KIND_READ,   8'h00);
    queue_item(dcbf_pkg::KIND_READ,   8'h00);  // visible entries used up: rejected
    queue_item(KIND_UNUSED,           8'h55);
    queue_item(dcbf_pkg::KIND_UPDATE, 8'h00);  // both events
    queue_item(dcbf_pkg::KIND_READ,   8'h00);
    queue_item(dcbf_pkg::KIND_UPDATE, 8'h00);  // read event only
    queue_item(dcbf_pkg::KIND_UPDATE, 8'h00);  // quiet phase
    // fill to the brim and beyond, then drain past empty
    queue_phase(dcbf_pkg::DEPTH + 1, 0);
    queue_phase(0, dcbf_pkg::DEPTH + 1);

    // random: mostly well-formed phases, some full/empty runs, some noise
    while (counted_items < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: queue_phase($urandom_range(0, dcbf_pkg::DEPTH + 1),
                                      $urandom_range(0, dcbf_pkg::DEPTH + 1));
        6: queue_phase(dcbf_pkg::DEPTH + 1, $urandom_range(0, 3));
        7: queue_phase($urandom_range(0, 3), dcbf_pkg::DEPTH + 1);
        default: begin
          repeat ($urandom_range(1, 8))
            queue_item(dcbf_pkg::KIND_W'($urandom_range(0, 3)),
                       dcbf_pkg::DATA_W'($urandom_range(0, 255)));
        end
      endcase
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (items_taken != total_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
